FILE: hw/rtl/rtls_pkg.sv
// Shared types and codes for the rigid task list scheduler.
package rtls_pkg;

   localparam int TIME_WIDTH  = 32;
   localparam int ID_WIDTH    = 16;
   localparam int COUNT_WIDTH = 7;
   localparam int MASK_WIDTH  = 16;

   localparam logic [1:0] STATUS_PLACED   = 2'd0;
   localparam logic [1:0] STATUS_TOO_MANY = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [1:0] CLASS_SEARCH = 2'd0;
   localparam logic [1:0] CLASS_ZERO   = 2'd1;
   localparam logic [1:0] CLASS_REJECT = 2'd2;

   typedef struct packed {
      logic                   start_new;
      logic [ID_WIDTH-1:0]    job_id;
      logic [TIME_WIDTH-1:0]  arrival_time;
      logic [COUNT_WIDTH-1:0] cores_needed;
      logic [TIME_WIDTH-1:0]  run_time;
   } req_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]   result_job_id;
      logic [TIME_WIDTH-1:0] start_time;
      logic [TIME_WIDTH-1:0] finish_time;
      logic [MASK_WIDTH-1:0] core_mask;
      logic [TIME_WIDTH-1:0] makespan;
      logic [1:0]            status;
   } rsp_type;

   typedef struct packed {
      req_type                job;
      logic [1:0]             job_class;
      logic [COUNT_WIDTH-1:0] act;
   } task_type;

endpackage

FILE: hw/rtl/rtls_front.sv
// Front end: holds the active core count and classifies each incoming job.
module rtls_front import rtls_pkg::*; #(
   parameter int NUM_CORES = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     csr_we,
   input  logic [4:0] csr_wdata,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     push_valid,
   input  logic     push_ready,
   output task_type push_data
);

   logic [4:0]             active_ff;
   logic [4:0]             active_in;
   logic [COUNT_WIDTH-1:0] active_ext;
   logic [COUNT_WIDTH-1:0] act;

   assign active_in  = csr_we ? csr_wdata : active_ff;
   assign active_ext = {2'b00, active_ff};
   assign act = (active_ext > COUNT_WIDTH'(NUM_CORES)) ? COUNT_WIDTH'(NUM_CORES) : active_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 5'd16;
      end else begin
         active_ff <= active_in;
      end
   end

   always_comb begin
      push_data.job = req_data;
      push_data.act = act;
      if (req_data.cores_needed > act) begin
         push_data.job_class = CLASS_REJECT;
      end else if (req_data.cores_needed == '0) begin
         push_data.job_class = CLASS_ZERO;
      end else begin
         push_data.job_class = CLASS_SEARCH;
      end
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

FILE: hw/rtl/rtls_queue.sv
// Two-entry queue of classified jobs between the front end and the engine.
module rtls_queue import rtls_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  task_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output task_type pop_data
);

   task_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/rtls_back.sv
// Placement engine: core free times, start search, core allocation and result register.
module rtls_back import rtls_pkg::*; #(
   parameter int NUM_CORES = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     pop_valid,
   output logic     pop_ready,
   input  task_type pop_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int IDX_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_ALLOC  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]             state_ff,  state_in;
   task_type               job_ff,    job_in;
   logic [IDX_W-1:0]       k_ff,      k_in;
   logic [COUNT_WIDTH-1:0] left_ff,   left_in;
   logic                   found_ff,  found_in;
   logic [TIME_WIDTH-1:0]  start_ff,  start_in;
   logic [TIME_WIDTH-1:0]  finish_ff, finish_in;
   logic [1:0]             status_ff, status_in;
   logic [NUM_CORES-1:0]   mask_ff,   mask_in;
   logic [TIME_WIDTH-1:0]  free_ff [NUM_CORES];
   logic [TIME_WIDTH-1:0]  free_in [NUM_CORES];
   logic [TIME_WIDTH-1:0]  ms_ff,     ms_in;
   rsp_type                rsp_ff,    rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [TIME_WIDTH-1:0]  cur_free;
   logic [TIME_WIDTH-1:0]  cand;
   logic [COUNT_WIDTH-1:0] free_cnt;
   logic [TIME_WIDTH:0]    sum;
   logic [TIME_WIDTH-1:0]  placed_ms;
   logic                   k_last;
   logic                   take;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      k_in         = k_ff;
      left_in      = left_ff;
      found_in     = found_ff;
      start_in     = start_ff;
      finish_in    = finish_ff;
      status_in    = status_ff;
      mask_in      = mask_ff;
      free_in      = free_ff;
      ms_in        = ms_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop_ready    = 1'b0;

      cur_free = free_ff[k_ff];
      cand = (cur_free > job_ff.job.arrival_time) ? cur_free : job_ff.job.arrival_time;
      // Active cores that are free by the candidate start time.
      free_cnt = '0;
      for (int j = 0; j < NUM_CORES; j++) begin
         if ((COUNT_WIDTH'(j) < job_ff.act) && (free_ff[j] <= cand)) begin
            free_cnt = free_cnt + COUNT_WIDTH'(1);
         end
      end
      sum       = {1'b0, start_ff} + {1'b0, job_ff.job.run_time};
      placed_ms = (finish_ff > ms_ff) ? finish_ff : ms_ff;
      k_last    = ((COUNT_WIDTH'(k_ff) + COUNT_WIDTH'(1)) == job_ff.act);
      take      = (cur_free <= start_ff);

      case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               job_in    = pop_data;
               k_in      = '0;
               left_in   = pop_data.job.cores_needed;
               found_in  = 1'b0;
               start_in  = '0;
               finish_in = '0;
               mask_in   = '0;
               status_in = STATUS_PLACED;
               // The clear applies even when the job itself is then rejected.
               if (pop_data.job.start_new) begin
                  for (int j = 0; j < NUM_CORES; j++) begin
                     free_in[j] = '0;
                  end
                  ms_in = '0;
               end
               case (pop_data.job_class)
                  CLASS_REJECT: begin
                     status_in = STATUS_TOO_MANY;
                     state_in  = ST_FINISH;
                  end
                  CLASS_ZERO: begin
                     start_in = pop_data.job.arrival_time;
                     state_in = ST_CHECK;
                  end
                  default: begin
                     state_in = ST_SEARCH;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if ((free_cnt >= job_ff.job.cores_needed) && (!found_ff || (cand < start_ff))) begin
               start_in = cand;
               found_in = 1'b1;
            end
            if (k_last) begin
               state_in = ST_CHECK;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_CHECK: begin
            if (sum[TIME_WIDTH]) begin
               status_in = STATUS_OVERFLOW;
               state_in  = ST_FINISH;
            end else begin
               finish_in = sum[TIME_WIDTH-1:0];
               k_in      = '0;
               if (job_ff.job.cores_needed == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_ALLOC;
               end
            end
         end
         ST_ALLOC: begin
            // Lowest-numbered free cores are taken until enough are held.
            if (take) begin
               free_in[k_ff] = finish_ff;
               mask_in[k_ff] = 1'b1;
               left_in       = left_ff - COUNT_WIDTH'(1);
            end
            if (k_last || (take && (left_ff == COUNT_WIDTH'(1)))) begin
               state_in = ST_FINISH;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.result_job_id = job_ff.job.job_id;
               rsp_in.start_time    = start_ff;
               rsp_in.finish_time   = finish_ff;
               rsp_in.core_mask     = MASK_WIDTH'(mask_ff);
               rsp_in.status        = status_ff;
               if (status_ff == STATUS_PLACED) begin
                  ms_in           = placed_ms;
                  rsp_in.makespan = placed_ms;
               end else begin
                  rsp_in.makespan = ms_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ms_ff        <= '0;
         for (int j = 0; j < NUM_CORES; j++) begin
            free_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ms_ff        <= ms_in;
         free_ff      <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      k_ff      <= k_in;
      left_ff   <= left_in;
      found_ff  <= found_in;
      start_ff  <= start_in;
      finish_ff <= finish_in;
      status_ff <= status_in;
      mask_ff   <= mask_in;
      rsp_ff    <= rsp_in;
   end

endmodule

FILE: hw/rtl/rigid_task_list_scheduler.sv
// Top level of the rigid task list scheduler: front end, job queue and placement engine.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_data  (rtls_pkg::req_type)
//   rsp      out        rsp_valid/rsp_ready  rsp_data  (rtls_pkg::rsp_type)
//   csr      in         csr_we               csr_wdata (active core count)
//
// The engine handles one item at a time. A rejected item goes from idle to the finish state,
// a zero-core item through the check state, and any other item through the start search
// of each active core, the check and an allocation scan that ends after the last core taken.
// Reset is synchronous; it clears all core free times, the makespan and the active count to 16.
// A two-entry queue lets items be accepted while the engine works or a result waits to be taken.
module rigid_task_list_scheduler import rtls_pkg::*; #(
   parameter int NUM_CORES = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [4:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic     push_valid;
   logic     push_ready;
   task_type push_data;
   logic     pop_valid;
   logic     pop_ready;
   task_type pop_data;

   rtls_front #(
      .NUM_CORES (NUM_CORES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   rtls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rtls_back #(
      .NUM_CORES (NUM_CORES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
